// ----- sv/ssc_pkg.sv -----
// Shared constants, types and helper functions for the Shell sort block.
package ssc_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 31;
	localparam int COUNT_W  = 32;
	// Positions 0..CAPACITY.
	localparam int IDX_W    = $clog2(CAPACITY + 1);
	// RAM holds positions 1..CAPACITY at address position-1.
	localparam int ADDR_W   = $clog2(CAPACITY);
	// Largest gap reached while growing is below 3*CAPACITY.
	localparam int GAP_W    = $clog2(3 * CAPACITY);
	// Reciprocal of 3, exact for every gap value below 2**(GAP_W+1).
	localparam int DIV3_SH  = GAP_W + 2;
	localparam int DIV3_MUL = (1 << DIV3_SH) / 3 + 1;
	localparam int PROD_W   = GAP_W + DIV3_SH;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [GAP_W-1:0]   gap_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		key_t  wdata;
		addr_t raddr;
	} ssc_mem_req_t;

	typedef struct packed {
		key_t   key;
		logic   end_of_run;
		count_t compare_count;
		count_t move_count;
		logic   overflowed;
	} ssc_beat_t;

	function automatic gap_t div3(input gap_t x);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(x) * PROD_W'(DIV3_MUL);
		return prod[DIV3_SH +: GAP_W];
	endfunction

	function automatic count_t sat_inc(input count_t x);
		return (x == '1) ? x : x + count_t'(1);
	endfunction

endpackage

// ----- sv/ssc_if.sv -----
// Valid/ready channel interfaces for key beats and result beats.
interface ssc_key_if import ssc_pkg::*; ();
	logic valid;
	logic ready;
	key_t key;
	logic last;

	modport source (output valid, output key, output last, input ready);
	modport sink (input valid, input key, input last, output ready);
endinterface

interface ssc_result_if import ssc_pkg::*; ();
	logic   valid;
	logic   ready;
	key_t   sorted_key;
	logic   end_of_run;
	count_t compare_count;
	count_t move_count;
	logic   overflowed;

	modport source (output valid, output sorted_key, output end_of_run,
		output compare_count, output move_count, output overflowed, input ready);
	modport sink (input valid, input sorted_key, input end_of_run,
		input compare_count, input move_count, input overflowed, output ready);
endinterface

// ----- sv/shell_sort_with_counts_core.sv -----
// Top level of the Shell sort block with comparison and move counting.
//
// Keys load one beat per cycle into a key store of CAPACITY entries; the
// beat marked last starts an ascending Shell sort on Knuth gaps
// (1, 4, 13, 40, ...) that walks the store through one registered read
// port and one write port, with one compare unit under a small sequencer.
// Keys that arrive with the store full are dropped and the set is flagged
// as overflowed. While sorting and emitting, the key channel is not ready.
// Steps per set of n keys: the gap is grown a step at a time, and each pass
// opens with a gap division; each position of a pass is read, captured and
// compared, with one more compare step per key shifted by the gap; when the
// walk hits the low bound, a placement step takes the place of the final
// compare. Each result beat is read and then emitted, and emitting waits
// while the output register is full. Every result beat carries the
// saturating 32-bit compare and move counts of the sort. Results pass
// through an output register, so the sequencer keeps going while one beat
// waits to be taken.
module shell_sort_with_counts_core import ssc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ssc_key_if.sink       keys,
	ssc_result_if.source  results
);

	ssc_mem_req_t mem_req;
	key_t         rdata;
	logic         push;
	logic         slot_free;
	ssc_beat_t    beat;

	logic         out_valid_q;
	ssc_beat_t    out_beat_q;

	ssc_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	ssc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (keys.valid),
		.key_ready (keys.ready),
		.key       (keys.key),
		.key_last  (keys.last),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.slot_free (slot_free),
		.push      (push),
		.beat      (beat)
	);

	// output register: free when empty or being drained this cycle
	assign slot_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// counts are captured per beat, so a new set may start sorting
	// while the last beat of the previous set still waits
	always_ff @(posedge clk) begin
		if (push) begin
			out_beat_q <= beat;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.sorted_key    = out_beat_q.key;
	assign results.end_of_run    = out_beat_q.end_of_run;
	assign results.compare_count = out_beat_q.compare_count;
	assign results.move_count    = out_beat_q.move_count;
	assign results.overflowed    = out_beat_q.overflowed;

endmodule

// ----- sv/ssc_ram.sv -----
// Key store: one write port, one registered read port.
module ssc_ram import ssc_pkg::*; (
	input  logic         clk,
	input  ssc_mem_req_t req,
	output key_t         rdata
);

	key_t mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

// ----- sv/ssc_engine.sv -----
// Sequencer: key load, Shell sort passes with counting, sorted read-out.
module ssc_engine import ssc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         key_valid,
	output logic         key_ready,
	input  key_t         key,
	input  logic         key_last,
	output ssc_mem_req_t mem_req,
	input  key_t         rdata,
	input  logic         slot_free,
	output logic         push,
	output ssc_beat_t    beat
);

	localparam logic [3:0] ST_LOAD    = 4'd0;
	localparam logic [3:0] ST_GROW    = 4'd1;
	localparam logic [3:0] ST_PASS    = 4'd2;
	localparam logic [3:0] ST_RDV     = 4'd3;
	localparam logic [3:0] ST_GETV    = 4'd4;
	localparam logic [3:0] ST_CMP     = 4'd5;
	localparam logic [3:0] ST_PLACE   = 4'd6;
	localparam logic [3:0] ST_EMIT_RD = 4'd7;
	localparam logic [3:0] ST_EMIT    = 4'd8;

	logic [3:0] state_q;
	idx_t       fill_q;
	logic       drop_q;
	count_t     cmp_q;
	count_t     mov_q;
	gap_t       h_q;
	idx_t       i_q;
	idx_t       j_q;
	idx_t       k_q;
	key_t       v_q;

	logic [GAP_W+1:0] h_grow;
	gap_t             h_div;
	idx_t             h_idx;
	idx_t             j_next;
	key_t             cmp_key;
	logic             shift;
	logic             pass_end;
	logic             emit_end;
	logic             load_acc;

	assign key_ready = (state_q == ST_LOAD);
	assign load_acc  = key_valid && key_ready;
	assign h_grow    = (GAP_W+2)'({h_q, 1'b0}) + (GAP_W+2)'(h_q) + (GAP_W+2)'(1);
	assign h_div     = div3(h_q);
	assign h_idx     = h_q[IDX_W-1:0];
	assign j_next    = j_q - h_idx;
	// position 0 is the zero sentinel
	assign cmp_key   = (j_q == h_idx) ? '0 : rdata;
	assign shift     = (cmp_key > v_q);
	assign pass_end  = (i_q == fill_q);
	assign emit_end  = (k_q == fill_q - idx_t'(1));
	assign push      = (state_q == ST_EMIT) && slot_free;

	always_comb begin
		beat.key           = rdata;
		beat.end_of_run    = emit_end;
		beat.compare_count = cmp_q;
		beat.move_count    = mov_q;
		beat.overflowed    = drop_q;
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = fill_q[ADDR_W-1:0];
		mem_req.wdata = key;
		mem_req.raddr = k_q[ADDR_W-1:0];
		unique case (state_q)
			ST_LOAD: begin
				mem_req.we = load_acc && (fill_q != idx_t'(CAPACITY));
			end
			ST_RDV: begin
				mem_req.raddr = ADDR_W'(i_q - idx_t'(1));
			end
			ST_GETV: begin
				mem_req.raddr = ADDR_W'(j_q - h_idx - idx_t'(1));
			end
			ST_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_W'(j_q - idx_t'(1));
				mem_req.wdata = shift ? cmp_key : v_q;
				mem_req.raddr = ADDR_W'(j_next - h_idx - idx_t'(1));
			end
			ST_PLACE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_W'(j_q - idx_t'(1));
				mem_req.wdata = v_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			drop_q  <= 1'b0;
			cmp_q   <= '0;
			mov_q   <= '0;
			h_q     <= gap_t'(1);
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (load_acc) begin
						if (fill_q != idx_t'(CAPACITY)) begin
							fill_q <= fill_q + idx_t'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (key_last) begin
							cmp_q   <= '0;
							mov_q   <= '0;
							h_q     <= gap_t'(1);
							state_q <= ST_GROW;
						end
					end
				end
				ST_GROW: begin
					h_q <= h_grow[GAP_W-1:0];
					if (h_grow >= (GAP_W+2)'(fill_q)) begin
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					h_q     <= h_div;
					i_q     <= h_div[IDX_W-1:0];
					state_q <= ST_RDV;
				end
				ST_RDV: begin
					j_q     <= i_q;
					mov_q   <= sat_inc(mov_q);
					state_q <= ST_GETV;
				end
				ST_GETV: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cmp_q <= sat_inc(cmp_q);
					mov_q <= sat_inc(mov_q);
					if (shift) begin
						j_q <= j_next;
						if (j_next < h_idx) begin
							state_q <= ST_PLACE;
						end
					end else if (pass_end) begin
						state_q <= (h_q == gap_t'(1)) ? ST_EMIT_RD : ST_PASS;
						k_q     <= '0;
					end else begin
						i_q     <= i_q + idx_t'(1);
						state_q <= ST_RDV;
					end
				end
				ST_PLACE: begin
					cmp_q <= sat_inc(cmp_q);
					mov_q <= sat_inc(mov_q);
					if (pass_end) begin
						state_q <= (h_q == gap_t'(1)) ? ST_EMIT_RD : ST_PASS;
						k_q     <= '0;
					end else begin
						i_q     <= i_q + idx_t'(1);
						state_q <= ST_RDV;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (emit_end) begin
							fill_q  <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + idx_t'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// v is captured the cycle after its read is issued
	always_ff @(posedge clk) begin
		if (state_q == ST_GETV) begin
			v_q <= rdata;
		end
	end

endmodule
